// ----- hw/rtl/pts_pkg.sv -----
package pts_pkg;

  localparam int unsigned IntervalWidth = 24;
  localparam int unsigned RetryWidth    = 4;
  localparam int unsigned CountWidth    = 16;
  localparam int unsigned IpWidth       = 32;
  localparam int unsigned PortWidth     = 8;
  localparam int unsigned CfgDataWidth  = IntervalWidth;

  localparam logic [IntervalWidth-1:0] IntervalReset = IntervalWidth'(1000 * 1000);
  localparam logic [RetryWidth-1:0]    RetryReset    = RetryWidth'(10);
  localparam logic [IntervalWidth-1:0] ElapsedMax    = '1;
  localparam logic [RetryWidth-1:0]    RetryMax      = '1;
  localparam logic [CountWidth-1:0]    CountMax      = '1;

  typedef enum logic [0:0] {
    REG_INTERVAL    = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_REPLY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CHK  = 3'd1,
    PH_ARP  = 3'd2,
    PH_PING = 3'd3,
    PH_END  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ARP    = 3'd1,
    ACT_ECHO   = 3'd2,
    ACT_DONE   = 3'd3,
    ACT_GAVEUP = 3'd4
  } action_e;

  typedef struct packed {
    logic [IntervalWidth-1:0] interval_ticks;
    logic [RetryWidth-1:0]    arp_retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            command;
    logic                  mac_known;
    logic [IpWidth-1:0]    dest_ip;
    logic [PortWidth-1:0]  port_number;
    logic [CountWidth-1:0] request_count;
  } item_t;

  typedef struct packed {
    action_e               action;
    logic [IpWidth-1:0]    target_ip;
    logic [PortWidth-1:0]  target_port;
    phase_e                phase_now;
    logic [CountWidth-1:0] sent_total;
    logic [CountWidth-1:0] ok_total;
    logic [CountWidth-1:0] fail_total;
  } result_t;

  function automatic logic [CountWidth-1:0] sat_inc16(input logic [CountWidth-1:0] v);
    sat_inc16 = (v == CountMax) ? v : v + CountWidth'(1);
  endfunction

endpackage

// ----- hw/rtl/pts_step.sv -----
module pts_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  pts_pkg::item_t  item_i,
  input  pts_pkg::cfg_t   cfg_i,
  output pts_pkg::result_t res_o
);

  pts_pkg::phase_e                     phase_q, phase_d;
  logic [pts_pkg::IntervalWidth-1:0]   elapsed_q, elapsed_d;
  logic [pts_pkg::RetryWidth-1:0]      retries_q, retries_d;
  logic [pts_pkg::CountWidth-1:0]      remaining_q, remaining_d;
  logic [pts_pkg::CountWidth-1:0]      tx_q, tx_d;
  logic [pts_pkg::CountWidth-1:0]      rx_q, rx_d;
  logic [pts_pkg::CountWidth-1:0]      ok_q, ok_d;
  logic [pts_pkg::CountWidth-1:0]      fail_q, fail_d;
  logic [pts_pkg::IpWidth-1:0]         ip_q, ip_d;
  logic [pts_pkg::PortWidth-1:0]       port_q, port_d;

  logic [pts_pkg::IntervalWidth-1:0]   elapsed_inc;
  logic [pts_pkg::RetryWidth-1:0]      retries_inc;
  logic [pts_pkg::CountWidth-1:0]      remaining_dec;
  logic                                due;
  pts_pkg::action_e                    action;

  // interval timer: saturating increment, due once it reaches the interval
  assign elapsed_inc = (elapsed_q == pts_pkg::ElapsedMax) ? elapsed_q
                                                          : elapsed_q + 1'b1;
  assign due         = (elapsed_inc >= cfg_i.interval_ticks);
  assign retries_inc = (retries_q == pts_pkg::RetryMax) ? retries_q : retries_q + 1'b1;
  assign remaining_dec = (remaining_q != '0) ? remaining_q - 1'b1 : remaining_q;

  always_comb begin
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    retries_d   = retries_q;
    remaining_d = remaining_q;
    tx_d        = tx_q;
    rx_d        = rx_q;
    ok_d        = ok_q;
    fail_d      = fail_q;
    ip_d        = ip_q;
    port_d      = port_q;
    action      = pts_pkg::ACT_NONE;

    unique case (item_i.command)
      pts_pkg::CMD_TICK: begin
        unique case (phase_q)
          pts_pkg::PH_IDLE: ;
          pts_pkg::PH_CHK: begin
            elapsed_d = '0;
            retries_d = '0;
            tx_d      = '0;
            rx_d      = '0;
            ok_d      = '0;
            fail_d    = '0;
            if (!item_i.mac_known) begin
              action  = pts_pkg::ACT_ARP;
              phase_d = pts_pkg::PH_ARP;
            end else begin
              phase_d = pts_pkg::PH_PING;
            end
          end
          pts_pkg::PH_ARP: begin
            elapsed_d = due ? '0 : elapsed_inc;
            if (due) begin
              if (!item_i.mac_known) begin
                retries_d = retries_inc;
                if (retries_inc >= cfg_i.arp_retry_limit) begin
                  remaining_d = '0;
                  phase_d     = pts_pkg::PH_IDLE;
                  action      = pts_pkg::ACT_GAVEUP;
                end
              end else begin
                phase_d = pts_pkg::PH_PING;
              end
            end
          end
          pts_pkg::PH_PING: begin
            elapsed_d = due ? '0 : elapsed_inc;
            if (due) begin
              // previous echo still open: count it as a timeout
              if (tx_q != rx_q) begin
                rx_d   = tx_q;
                fail_d = pts_pkg::sat_inc16(fail_q);
              end
              action      = pts_pkg::ACT_ECHO;
              tx_d        = pts_pkg::sat_inc16(tx_q);
              remaining_d = remaining_dec;
              if (remaining_dec == '0) begin
                phase_d = pts_pkg::PH_END;
              end
            end
          end
          pts_pkg::PH_END: begin
            elapsed_d = due ? '0 : elapsed_inc;
            if (due) begin
              if (tx_q != rx_q) begin
                rx_d   = tx_q;
                fail_d = pts_pkg::sat_inc16(fail_q);
              end
              phase_d = pts_pkg::PH_IDLE;
              action  = pts_pkg::ACT_DONE;
            end
          end
          default: phase_d = pts_pkg::PH_IDLE;
        endcase
      end
      pts_pkg::CMD_START: begin
        if (phase_q == pts_pkg::PH_IDLE && item_i.request_count != '0) begin
          ip_d        = item_i.dest_ip;
          port_d      = item_i.port_number;
          remaining_d = item_i.request_count;
          phase_d     = pts_pkg::PH_CHK;
        end
      end
      pts_pkg::CMD_REPLY: begin
        if ((phase_q == pts_pkg::PH_PING || phase_q == pts_pkg::PH_END) &&
            rx_q != tx_q) begin
          rx_d = pts_pkg::sat_inc16(rx_q);
          ok_d = pts_pkg::sat_inc16(ok_q);
        end
      end
      default: ;
    endcase

    res_o.action      = action;
    res_o.target_ip   = ip_d;
    res_o.target_port = port_d;
    res_o.phase_now   = phase_d;
    res_o.sent_total  = tx_d;
    res_o.ok_total    = ok_d;
    res_o.fail_total  = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pts_pkg::PH_IDLE;
      elapsed_q   <= '0;
      retries_q   <= '0;
      remaining_q <= '0;
      tx_q        <= '0;
      rx_q        <= '0;
      ok_q        <= '0;
      fail_q      <= '0;
      ip_q        <= '0;
      port_q      <= '0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      retries_q   <= retries_d;
      remaining_q <= remaining_d;
      tx_q        <= tx_d;
      rx_q        <= rx_d;
      ok_q        <= ok_d;
      fail_q      <= fail_d;
      ip_q        <= ip_d;
      port_q      <= port_d;
    end
  end

endmodule

// ----- hw/rtl/ping_test_sequencer.sv -----
// Result path: an accepted item enters the input register, then moves into the result
//   register, from which the result is offered.
// Throughput: one item per cycle unless results stall; sequencer state updates once per item.
// Input and result stages are decoupled: an item is taken into an empty input register while a result waits.
// Reset: rst_ni async active low; phase idle, all counters and saved target zero,
//   interval_ticks 1000000, arp_retry_limit 10, both pipeline stages empty.
module ping_test_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [pts_pkg::CfgDataWidth-1:0]     cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           command_i,
  input  logic                                 mac_known_i,
  input  logic [pts_pkg::IpWidth-1:0]          dest_ip_i,
  input  logic [pts_pkg::PortWidth-1:0]        port_number_i,
  input  logic [pts_pkg::CountWidth-1:0]       request_count_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           action_o,
  output logic [pts_pkg::IpWidth-1:0]          target_ip_o,
  output logic [pts_pkg::PortWidth-1:0]        target_port_o,
  output logic [2:0]                           phase_now_o,
  output logic [pts_pkg::CountWidth-1:0]       sent_total_o,
  output logic [pts_pkg::CountWidth-1:0]       ok_total_o,
  output logic [pts_pkg::CountWidth-1:0]       fail_total_o
);

  // config registers; the user writes them only while idle, the block does not enforce it
  pts_pkg::cfg_t    cfg_q, cfg_d;

  // input stage
  logic             in_valid_q, in_valid_d;
  pts_pkg::item_t   item_q, item_d;
  logic             in_xfer;

  // result stage
  logic             out_valid_q, out_valid_d;
  pts_pkg::result_t res_q, res_d;
  pts_pkg::result_t step_res;

  // item in the input register moves to the result register when that
  // register is empty or its result leaves this cycle
  logic             advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pts_pkg::REG_INTERVAL:    cfg_d.interval_ticks  = cfg_data_i;
        pts_pkg::REG_RETRY_LIMIT: cfg_d.arp_retry_limit = cfg_data_i[pts_pkg::RetryWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (in_xfer) begin
      in_valid_d           = 1'b1;
      item_d.command       = command_i;
      item_d.mac_known     = mac_known_i;
      item_d.dest_ip       = dest_ip_i;
      item_d.port_number   = port_number_i;
      item_d.request_count = request_count_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      res_d       = step_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state machine and counters; state commits when the item advances
  pts_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ticks  <= pts_pkg::IntervalReset;
      cfg_q.arp_retry_limit <= pts_pkg::RetryReset;
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = res_q.action;
  assign target_ip_o   = res_q.target_ip;
  assign target_port_o = res_q.target_port;
  assign phase_now_o   = res_q.phase_now;
  assign sent_total_o  = res_q.sent_total;
  assign ok_total_o    = res_q.ok_total;
  assign fail_total_o  = res_q.fail_total;

  // replies are only counted against open echoes
  a_ok_le_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ok_total_o <= sent_total_o))
    else $error("ok count exceeds sent count");

  // an echo is only requested while pinging; the ping phase may end on it
  a_echo_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res_q.action == pts_pkg::ACT_ECHO) |->
      (res_q.phase_now == pts_pkg::PH_PING || res_q.phase_now == pts_pkg::PH_END))
    else $error("echo outside ping phase");

  // finishing or giving up always returns to idle
  a_term_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (res_q.action == pts_pkg::ACT_DONE ||
                     res_q.action == pts_pkg::ACT_GAVEUP)) |->
      (res_q.phase_now == pts_pkg::PH_IDLE))
    else $error("terminal action without idle phase");

  // a result held by the sink is never overwritten
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result changed");

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  // Command code with no meaning; the sequencer must ignore it.
  localparam logic [1:0] CmdIgnored = 2'd3;
  // A tick index no test reaches: the MAC never becomes known by tick count alone.
  localparam int unsigned MacNever = 32'hFFFF_FFFF;
  localparam int unsigned TrafficGoal = 1250;

  logic clk_i;
  logic rst_ni;

  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;

  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               command_i;
  logic                     mac_known_i;
  logic [IpWidth-1:0]       dest_ip_i;
  logic [PortWidth-1:0]     port_number_i;
  logic [CountWidth-1:0]    request_count_i;

  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [2:0]               action_o;
  logic [IpWidth-1:0]       target_ip_o;
  logic [PortWidth-1:0]     target_port_o;
  logic [2:0]               phase_now_o;
  logic [CountWidth-1:0]    sent_total_o;
  logic [CountWidth-1:0]    ok_total_o;
  logic [CountWidth-1:0]    fail_total_o;

  ping_test_sequencer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .mac_known_i,
    .dest_ip_i,
    .port_number_i,
    .request_count_i,
    .out_valid_o,
    .out_stall_i,
    .action_o,
    .target_ip_o,
    .target_port_o,
    .phase_now_o,
    .sent_total_o,
    .ok_total_o,
    .fail_total_o
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  item_t   pending_cmds[$];      // commands waiting for the driver
  result_t expected_status[$];   // predicted status, oldest first

  logic        in_taken  = 1'b0; // input transfer at the last rising edge
  logic        out_taken = 1'b0; // result transfer at the last rising edge
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;
  int unsigned hold_len  = 0;    // long receiver hold-off, in cycles
  int unsigned hold_seq  = 0;    // bumped to request a hold-off
  int unsigned mismatches = 0;
  int unsigned traffic_items = 0;
  int unsigned sess_ticks = 0;   // ticks queued since the current test began

  // ---------------------------------------------------------------------------
  // Sequencer predictor: own copy of the registers and the test state
  // ---------------------------------------------------------------------------
  logic [IntervalWidth-1:0] cur_interval    = IntervalReset;
  logic [RetryWidth-1:0]    cur_retry_limit = RetryReset;

  phase_e                   seq_phase     = PH_IDLE;
  logic [IntervalWidth-1:0] tick_count    = '0;
  logic [RetryWidth-1:0]    arp_tries     = '0;
  logic [CountWidth-1:0]    echoes_left   = '0;
  logic [CountWidth-1:0]    echoes_sent   = '0;
  logic [CountWidth-1:0]    echoes_closed = '0;
  logic [CountWidth-1:0]    replies_ok    = '0;
  logic [CountWidth-1:0]    echoes_failed = '0;
  logic [IpWidth-1:0]       peer_ip       = '0;
  logic [PortWidth-1:0]     peer_port     = '0;

  function automatic logic [CountWidth-1:0] count_up(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Advance the interval timer; true when an interval has run out.
  function automatic logic interval_over();
    if (tick_count != ElapsedMax) tick_count = tick_count + 1'b1;
    if (tick_count >= cur_interval) begin
      tick_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // An echo still waiting for its reply is written off as a failure.
  function automatic void write_off_echo();
    if (echoes_sent != echoes_closed) begin
      echoes_closed = echoes_sent;
      echoes_failed = count_up(echoes_failed);
    end
  endfunction

  function automatic action_e tick_phase(input logic known);
    action_e act;
    act = ACT_NONE;
    case (seq_phase)
      PH_IDLE: ;
      PH_CHK: begin
        tick_count    = '0;
        arp_tries     = '0;
        echoes_sent   = '0;
        echoes_closed = '0;
        replies_ok    = '0;
        echoes_failed = '0;
        if (!known) begin
          act = ACT_ARP;
          seq_phase = PH_ARP;
        end else begin
          seq_phase = PH_PING;
        end
      end
      PH_ARP: if (interval_over()) begin
        if (!known) begin
          if (arp_tries != RetryMax) arp_tries = arp_tries + 1'b1;
          if (arp_tries >= cur_retry_limit) begin
            echoes_left = '0;
            seq_phase = PH_IDLE;
            act = ACT_GAVEUP;
          end
        end else begin
          seq_phase = PH_PING;
        end
      end
      PH_PING: if (interval_over()) begin
        write_off_echo();
        act = ACT_ECHO;
        echoes_sent = count_up(echoes_sent);
        if (echoes_left != '0) echoes_left = echoes_left - 1'b1;
        if (echoes_left == '0) seq_phase = PH_END;
      end
      PH_END: if (interval_over()) begin
        write_off_echo();
        seq_phase = PH_IDLE;
        act = ACT_DONE;
      end
      default: seq_phase = PH_IDLE;
    endcase
    return act;
  endfunction

  function automatic result_t predict_status(input item_t cmd);
    result_t r;
    action_e act;
    act = ACT_NONE;
    case (cmd.command)
      CMD_TICK: act = tick_phase(cmd.mac_known);
      CMD_START: if (seq_phase == PH_IDLE && cmd.request_count != '0) begin
        peer_ip     = cmd.dest_ip;
        peer_port   = cmd.port_number;
        echoes_left = cmd.request_count;
        seq_phase   = PH_CHK;
      end
      CMD_REPLY: if ((seq_phase == PH_PING || seq_phase == PH_END) &&
                     echoes_closed != echoes_sent) begin
        echoes_closed = count_up(echoes_closed);
        replies_ok    = count_up(replies_ok);
      end
      default: ;
    endcase
    r.action      = act;
    r.target_ip   = peer_ip;
    r.target_port = peer_port;
    r.phase_now   = seq_phase;
    r.sent_total  = echoes_sent;
    r.ok_total    = replies_ok;
    r.fail_total  = echoes_failed;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. The result check runs
  // before the new prediction is queued, so an unexpected result can never be
  // matched against a command taken in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    item_t   cmd;
    result_t want;
    in_taken  <= rst_ni && in_valid_i && !in_stall_o;
    out_taken <= rst_ni && out_valid_o && !out_stall_i;

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        $error("status transfer with nothing expected: action %0d phase %0d",
               action_o, phase_now_o);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        check_field("action",      want.action,      action_o);
        check_field("target_ip",   want.target_ip,   target_ip_o);
        check_field("target_port", want.target_port, target_port_o);
        check_field("phase_now",   want.phase_now,   phase_now_o);
        check_field("sent_total",  want.sent_total,  sent_total_o);
        check_field("ok_total",    want.ok_total,    ok_total_o);
        check_field("fail_total",  want.fail_total,  fail_total_o);
      end
    end

    // Predict at acceptance, from the values actually on the input ports.
    if (rst_ni && in_valid_i && !in_stall_o) begin
      cmd = '{command: command_i, mac_known: mac_known_i, dest_ip: dest_ip_i,
              port_number: port_number_i, request_count: request_count_i};
      expected_status.push_back(predict_status(cmd));
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs move at the falling edge. An offered command is held until
  // its transfer; then, with src_idle_on set, a random gap is drawn before the next one.
  // ---------------------------------------------------------------------------
  int unsigned src_gap = 0;

  always @(negedge clk_i) begin
    item_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_valid_i) src_gap = src_idle_on ? $urandom_range(0, 8) : 0;
      if (src_gap != 0) begin
        src_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        command_i       <= nxt.command;
        mac_known_i     <= nxt.mac_known;
        dest_ip_i       <= nxt.dest_ip;
        port_number_i   <= nxt.port_number;
        request_count_i <= nxt.request_count;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: with snk_idle_on set, stall for a random span after each transfer; a requested
  // hold-off overrides that and is counted down here.
  // ---------------------------------------------------------------------------
  int unsigned snk_wait  = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;

  always @(negedge clk_i) begin
    if (out_taken) snk_wait = snk_idle_on ? $urandom_range(0, 8) : 0;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (snk_wait != 0) begin
      snk_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_cmd(input logic [1:0] c, input logic k,
                                  input logic [IpWidth-1:0] ip,
                                  input logic [PortWidth-1:0] pt,
                                  input logic [CountWidth-1:0] n);
    pending_cmds.push_back('{command: c, mac_known: k, dest_ip: ip,
                             port_number: pt, request_count: n});
  endfunction

  // Wait until every queued command went through and every status came back.
  // Checked just after the falling edge so that driver updates have settled.
  task automatic drain();
    do begin
      @(negedge clk_i);
      #1;
    end while (pending_cmds.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Register writes only happen with the pipeline empty.
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_INTERVAL) cur_interval = val;
    else cur_retry_limit = val[RetryWidth-1:0];
  endtask

  // Feed ticks, replies and some noise in chunks until the test is over or 200 chunks have gone.
  // The MAC becomes known once known_after ticks have gone by.
  task automatic keep_going(input int unsigned known_after);
    int unsigned chunks;
    int unsigned pick;
    logic        known;
    chunks = 0;
    do begin
      repeat (12) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          known = (sess_ticks >= known_after);
          if ($urandom_range(0, 15) == 0) known = 1'($urandom);
          sess_ticks++;
          add_cmd(CMD_TICK, known, $urandom, 8'($urandom), 16'($urandom));
        end else if (pick < 88) begin
          add_cmd(CMD_REPLY, 1'($urandom), $urandom, 8'($urandom), 16'($urandom));
        end else if (pick < 95) begin
          // a start with a small count; taken only if the test just ended
          add_cmd(CMD_START, 1'($urandom), $urandom, 8'($urandom),
                  16'($urandom_range(0, 4)));
        end else begin
          add_cmd(CmdIgnored, 1'($urandom), $urandom, 8'($urandom), 16'($urandom));
        end
        traffic_items++;
      end
      drain();
      chunks++;
    end while (seq_phase != PH_IDLE && chunks < 200);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned     sessions;
    int unsigned     known_after;
    logic [CountWidth-1:0] big_count;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    command_i       = CMD_TICK;
    mac_known_i     = 1'b0;
    dest_ip_i       = '0;
    port_number_i   = '0;
    request_count_i = '0;
    out_stall_i     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one full test with ARP, a missed reply and a reply in end.
    write_reg(REG_INTERVAL, 24'd1);
    write_reg(REG_RETRY_LIMIT, 24'd2);
    add_cmd(CMD_TICK,   1'b1, 32'h0,         8'h00, 16'h0000); // tick while idle
    add_cmd(CMD_REPLY,  1'b0, 32'h0,         8'h00, 16'h0000); // reply while idle
    add_cmd(CmdIgnored, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    add_cmd(CMD_START,  1'b0, 32'hAAAA_5555, 8'h55, 16'h0000); // zero count
    add_cmd(CMD_START,  1'b0, 32'hFFFF_FFFF, 8'hFF, 16'd3);
    add_cmd(CMD_START,  1'b1, 32'h0,         8'h00, 16'hFFFF); // busy
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // MAC unknown: ARP
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // one retry
    add_cmd(CMD_TICK,   1'b1, 32'h0,         8'h00, 16'h0000); // MAC learned
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // echo 1
    add_cmd(CMD_REPLY,  1'b0, 32'h0,         8'h00, 16'h0000);
    add_cmd(CMD_REPLY,  1'b0, 32'h0,         8'h00, 16'h0000); // none outstanding
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // echo 2
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // echo 3, echo 2 fails
    add_cmd(CMD_REPLY,  1'b0, 32'h0,         8'h00, 16'h0000); // reply in end
    add_cmd(CMD_TICK,   1'b0, 32'h0,         8'h00, 16'h0000); // finished
    drain();

    // Zero interval and zero retry limit: gives up at the first ARP retry.
    write_reg(REG_INTERVAL, 24'd0);
    write_reg(REG_RETRY_LIMIT, {20'hFFFFF, 4'd0});
    add_cmd(CMD_START, 1'b1, 32'h0, 8'h00, 16'd1);
    add_cmd(CMD_TICK,  1'b0, 32'h0, 8'h00, 16'h0000);
    add_cmd(CMD_TICK,  1'b0, 32'h0, 8'h00, 16'h0000);
    drain();

    // Longest interval: pinging but never due until the interval shrinks.
    write_reg(REG_INTERVAL, ElapsedMax);
    write_reg(REG_RETRY_LIMIT, {20'h0, 4'd15});
    add_cmd(CMD_START, 1'b0, 32'h1234_5678, 8'h5A, 16'd1);
    add_cmd(CMD_TICK,  1'b1, 32'h0, 8'h00, 16'h0000);
    add_cmd(CMD_TICK,  1'b1, 32'h0, 8'h00, 16'h0000);
    add_cmd(CMD_REPLY, 1'b1, 32'h0, 8'h00, 16'h0000);
    drain();
    write_reg(REG_INTERVAL, 24'd1);
    sess_ticks = 0;
    keep_going(0);

    // Random tests with fresh register settings each time.
    sessions = 0;
    while (traffic_items < TrafficGoal) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       write_reg(REG_INTERVAL, 24'd0);
        6:       write_reg(REG_INTERVAL, 24'($urandom_range(4, 8)));
        7:       write_reg(REG_INTERVAL, 24'd1);
        default: write_reg(REG_INTERVAL, 24'($urandom_range(1, 3)));
      endcase
      write_reg(REG_RETRY_LIMIT, {20'($urandom), 4'($urandom_range(0, 15))});
      case ($urandom_range(0, 3))
        0:       known_after = 0;
        1:       known_after = $urandom_range(1, 6);
        2:       known_after = $urandom_range(1, 40);
        default: known_after = MacNever;
      endcase

      // One test runs against a long receiver hold-off with a steady sender,
      // so the pipeline backs up and stalls the input.
      if (sessions == 5) begin
        src_idle_on = 1'b0;
        hold_len = 300;
        hold_seq++;
      end

      sess_ticks = 0;
      add_cmd(CMD_START, 1'($urandom), $urandom, 8'($urandom),
              16'($urandom_range(1, 6)));
      // a second start lands in check MAC and must be ignored
      if ($urandom_range(0, 1) == 0)
        add_cmd(CMD_START, 1'($urandom), $urandom, 8'($urandom), 16'($urandom));
      traffic_items++;
      keep_going(known_after);
      sessions++;
    end

    // Large count at the end: the test cannot finish its echoes before the run stops.
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    write_reg(REG_INTERVAL, 24'd0);
    big_count = {1'b1, 15'($urandom)};
    add_cmd(CMD_START, 1'b1, $urandom, 8'($urandom), big_count);
    repeat (40) begin
      if ($urandom_range(0, 2) == 0)
        add_cmd(CMD_REPLY, 1'($urandom), $urandom, 8'($urandom), 16'($urandom));
      else
        add_cmd(CMD_TICK, 1'($urandom), $urandom, 8'($urandom), 16'($urandom));
    end
    drain();
    repeat (8) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pts_pkg.sv
hw/rtl/pts_step.sv
hw/rtl/ping_test_sequencer.sv
sim/testbench.sv
